/* rtl/core/lsps_pkg.sv */
// Shared types, constants and the pattern-to-offset table for the line sensor
// PI steering block. No dependencies.

package lsps_pkg;

  localparam int unsigned SensorCount = 8;
  localparam int unsigned SampleW     = 8;
  localparam int unsigned ErrW        = 5;
  localparam int unsigned AccW        = 16;
  localparam int unsigned PGainW      = 10;
  localparam int unsigned IGainW      = 10;
  localparam int unsigned SpeedW      = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned WhiteMinOnes = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_THRESHOLDS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_SPEED  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN_SPEED  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_REL_MODE   = 3'd5;

  localparam logic [CfgDataW-1:0] ThresholdsReset = 64'h7070_7070_7070_7070;
  localparam logic [PGainW-1:0]   PropGainReset   = 10'd125;
  localparam logic [IGainW-1:0]   IntegGainReset  = 10'd77;
  localparam logic [SpeedW-1:0]   MaxSpeedReset   = 8'd255;
  localparam logic [SpeedW-1:0]   MinSpeedReset   = 8'd0;

  localparam logic signed [ErrW-1:0] ErrLostPos = 5'sd8;
  localparam logic signed [ErrW-1:0] ErrLostNeg = -5'sd8;

  typedef enum logic [1:0] {
    CLS_EMPTY,
    CLS_HIT,
    CLS_MISS
  } pat_cls_e;

  typedef struct packed {
    logic [SensorCount-1:0]   pattern;
    logic                     white;
    pat_cls_e                 cls;
    logic signed [ErrW-1:0]   offset;
  } lsps_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [ErrW-1:0]   offset;
  } lsps_lookup_t;

  function automatic lsps_lookup_t pattern_lookup(input logic [SensorCount-1:0] pat);
    lsps_lookup_t r;
    r.hit    = 1'b1;
    r.offset = '0;
    unique case (pat)
      8'h01:          r.offset = 5'sd7;
      8'h03, 8'h07:   r.offset = 5'sd6;
      8'h02:          r.offset = 5'sd5;
      8'h06, 8'h0E:   r.offset = 5'sd4;
      8'h04:          r.offset = 5'sd3;
      8'h0C, 8'h1C:   r.offset = 5'sd2;
      8'h08:          r.offset = 5'sd1;
      8'h18:          r.offset = 5'sd0;
      8'h10:          r.offset = -5'sd1;
      8'h30, 8'h38:   r.offset = -5'sd2;
      8'h20:          r.offset = -5'sd3;
      8'h60, 8'h70:   r.offset = -5'sd4;
      8'h40:          r.offset = -5'sd5;
      8'hC0, 8'hE0:   r.offset = -5'sd6;
      8'h80:          r.offset = -5'sd7;
      default:        r.hit    = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/lsps_front.sv */
// Front end: thresholds the eight samples, applies white-line inversion and
// classifies the pattern through the package table. Uses lsps_pkg.

module lsps_front (
  input  logic [lsps_pkg::SampleW-1:0]  samples_i [lsps_pkg::SensorCount],
  input  logic [lsps_pkg::CfgDataW-1:0] thresholds_i,
  input  logic                          relative_mode_i,
  output lsps_pkg::lsps_item_t          item_o
);
  import lsps_pkg::*;

  logic [SensorCount-1:0] raw_pat;
  logic [SensorCount-1:0] pat;
  logic [3:0]             ones;
  logic                   white;
  lsps_lookup_t           look;

  always_comb begin
    for (int i = 0; i < SensorCount; i++) begin
      raw_pat[i] = samples_i[i] > thresholds_i[i*SampleW +: SampleW];
    end
  end

  always_comb begin
    ones = '0;
    for (int i = 0; i < SensorCount; i++) begin
      ones = ones + {3'b000, raw_pat[i]};
    end
  end

  assign white = relative_mode_i && (ones >= 4'(WhiteMinOnes));
  assign pat   = white ? ~raw_pat : raw_pat;
  assign look  = pattern_lookup(pat);

  always_comb begin
    item_o.pattern = pat;
    item_o.white   = white;
    item_o.offset  = look.offset;
    if (pat == '0) begin
      item_o.cls = CLS_EMPTY;
    end else if (look.hit) begin
      item_o.cls = CLS_HIT;
    end else begin
      item_o.cls = CLS_MISS;
    end
  end

endmodule

/* rtl/core/lsps_queue.sv */
// Short FIFO of classified words between front and back end.
// Uses lsps_pkg for the word type.

module lsps_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lsps_pkg::lsps_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output lsps_pkg::lsps_item_t item_o
);
  import lsps_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lsps_item_t         mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/core/lsps_back.sv */
// Back end: resolves the position error, updates the leaky integral,
// forms the drive and clamps both motor duties. Uses lsps_pkg.

module lsps_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  lsps_pkg::lsps_item_t              q_item_i,
  output logic                              q_pop_o,
  input  logic [lsps_pkg::PGainW-1:0]       prop_gain_i,
  input  logic [lsps_pkg::IGainW-1:0]       integ_gain_i,
  input  logic [lsps_pkg::SpeedW-1:0]       max_speed_i,
  input  logic [lsps_pkg::SpeedW-1:0]       min_speed_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lsps_pkg::SpeedW-1:0]       left_duty_o,
  output logic [lsps_pkg::SpeedW-1:0]       right_duty_o,
  output logic [lsps_pkg::SensorCount-1:0]  line_pattern_o,
  output logic                              line_is_white_o,
  output logic signed [lsps_pkg::ErrW-1:0]  position_error_o
);
  import lsps_pkg::*;

  localparam int unsigned SumW   = AccW + 1;
  localparam int unsigned ProdW  = SumW + IGainW + 1;
  localparam int unsigned QuotW  = ProdW - 8;
  localparam int unsigned PErrW  = PGainW + ErrW;
  localparam int unsigned DriveW = AccW + 1;
  localparam int unsigned DutyW  = DriveW + 1;

  // loop state
  logic signed [ErrW-1:0]   last_err_q;
  logic signed [AccW-1:0]   integ_q;

  // stage A
  logic                     a_valid_q;
  logic signed [ErrW-1:0]   a_err_q;
  logic signed [AccW-1:0]   a_integ_q;
  logic signed [PErrW-1:0]  a_perr_q;
  logic [SensorCount-1:0]   a_pat_q;
  logic                     a_white_q;

  // output register
  logic                     out_valid_q;
  logic [SpeedW-1:0]        left_q, right_q;
  logic [SensorCount-1:0]   pat_q;
  logic                     white_q;
  logic signed [ErrW-1:0]   err_q;

  logic                     out_ready, a_ready;
  logic signed [ErrW-1:0]   err_d;
  logic signed [SumW-1:0]   sum;
  logic signed [ProdW-1:0]  prod;
  logic signed [QuotW-1:0]  quot;
  logic signed [AccW-1:0]   integ_d;
  logic signed [PErrW-1:0]  perr;
  logic signed [DriveW-1:0] drive;
  logic signed [DutyW-1:0]  left_raw, right_raw;
  logic [SpeedW-1:0]        left_d, right_d;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign a_ready   = !a_valid_q || out_ready;
  assign q_pop_o   = q_valid_i && a_ready;

  always_comb begin
    case (q_item_i.cls)
      CLS_EMPTY: begin
        if (last_err_q < 0) begin
          err_d = ErrLostNeg;
        end else if (last_err_q > 0) begin
          err_d = ErrLostPos;
        end else begin
          err_d = '0;
        end
      end
      CLS_HIT:  err_d = q_item_i.offset;
      default:  err_d = last_err_q;
    endcase
  end

  // integral: trunc toward zero of (acc + err) * gain / 256, saturated
  always_comb begin
    sum  = SumW'(integ_q) + SumW'(err_d);
    prod = ProdW'(sum) * ProdW'($signed({1'b0, integ_gain_i}));
    quot = QuotW'(prod >>> 8);
    if (prod < 0 && prod[7:0] != '0) begin
      quot = quot + 1'b1;
    end
    if (quot > QuotW'(32767)) begin
      integ_d = 16'sh7FFF;
    end else if (quot < -QuotW'(32768)) begin
      integ_d = -16'sh8000;
    end else begin
      integ_d = AccW'(quot);
    end
    perr = PErrW'($signed({1'b0, prop_gain_i})) * PErrW'(err_d);
  end

  function automatic logic [SpeedW-1:0] clamp_duty(input logic signed [DutyW-1:0] v,
                                                   input logic [SpeedW-1:0] lo,
                                                   input logic [SpeedW-1:0] hi);
    logic signed [DutyW-1:0] t;
    t = (v < $signed({{(DutyW-SpeedW){1'b0}}, lo})) ?
        $signed({{(DutyW-SpeedW){1'b0}}, lo}) : v;
    if (t > $signed({{(DutyW-SpeedW){1'b0}}, hi})) begin
      t = $signed({{(DutyW-SpeedW){1'b0}}, hi});
    end
    return t[SpeedW-1:0];
  endfunction

  always_comb begin
    drive     = DriveW'(a_perr_q) + DriveW'(a_integ_q);
    left_raw  = $signed({{(DutyW-SpeedW){1'b0}}, max_speed_i}) + DutyW'(drive);
    right_raw = $signed({{(DutyW-SpeedW){1'b0}}, max_speed_i}) - DutyW'(drive);
    left_d    = clamp_duty(left_raw, min_speed_i, max_speed_i);
    right_d   = clamp_duty(right_raw, min_speed_i, max_speed_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q  <= '0;
      integ_q     <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        last_err_q <= err_d;
        integ_q    <= integ_d;
      end
      if (a_ready) begin
        a_valid_q <= q_pop_o;
      end
      if (out_ready) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_err_q   <= err_d;
      a_integ_q <= integ_d;
      a_perr_q  <= perr;
      a_pat_q   <= q_item_i.pattern;
      a_white_q <= q_item_i.white;
    end
    if (out_ready && a_valid_q) begin
      left_q  <= left_d;
      right_q <= right_d;
      pat_q   <= a_pat_q;
      white_q <= a_white_q;
      err_q   <= a_err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_duty_o      = left_q;
  assign right_duty_o     = right_q;
  assign line_pattern_o   = pat_q;
  assign line_is_white_o  = white_q;
  assign position_error_o = err_q;

endmodule

/* rtl/core/line_sensor_pi_steering.sv */
// Top level of the line sensor PI steering controller: configuration
// registers, front end, word queue and back end. Uses lsps_pkg.
//
// Usage:
//  - Input channel: in_valid_i with sample_0_i..sample_7_i; a word is taken
//    on a rising edge with in_valid_i high and in_stall_o low.
//  - Output channel: out_valid_o with the duties, pattern, white flag and
//    position error; a word leaves on an edge with out_stall_i low.
//  - Config: cfg_we_i writes cfg_wdata_i to register cfg_index_i
//    (0 thresholds, 1 prop gain, 2 integ gain, 3 max, 4 min, 5 relative).
//    Unknown indexes are ignored. Write only while the block is empty.
//  - Path: a word goes from the queue through stage A to the output register.
//  - Throughput: one word per cycle without a receiver stall; the back end
//    updates error and integral at the pop; consecutive words never wait on it.
//  - Receiver stall: the output register holds, the back end stops, the
//    queue (QueueDepth words) fills, then in_stall_o rises.
//  - Reset: clears config to defaults, the last error and the integral,
//    and empties the queue and pipeline.

module line_sensor_pi_steering #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lsps_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lsps_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lsps_pkg::SampleW-1:0]        sample_0_i,
  input  logic [lsps_pkg::SampleW-1:0]        sample_1_i,
  input  logic [lsps_pkg::SampleW-1:0]        sample_2_i,
  input  logic [lsps_pkg::SampleW-1:0]        sample_3_i,
  input  logic [lsps_pkg::SampleW-1:0]        sample_4_i,
  input  logic [lsps_pkg::SampleW-1:0]        sample_5_i,
  input  logic [lsps_pkg::SampleW-1:0]        sample_6_i,
  input  logic [lsps_pkg::SampleW-1:0]        sample_7_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lsps_pkg::SpeedW-1:0]         left_duty_o,
  output logic [lsps_pkg::SpeedW-1:0]         right_duty_o,
  output logic [lsps_pkg::SensorCount-1:0]    line_pattern_o,
  output logic                                line_is_white_o,
  output logic signed [lsps_pkg::ErrW-1:0]    position_error_o
);
  import lsps_pkg::*;

  logic [CfgDataW-1:0] thresholds_q;
  logic [PGainW-1:0]   prop_gain_q;
  logic [IGainW-1:0]   integ_gain_q;
  logic [SpeedW-1:0]   max_speed_q;
  logic [SpeedW-1:0]   min_speed_q;
  logic                relative_mode_q;

  logic [SampleW-1:0]  samples [SensorCount];
  lsps_item_t          front_item;
  lsps_item_t          q_item;
  logic                q_full, q_valid, q_pop, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresholds_q    <= ThresholdsReset;
      prop_gain_q     <= PropGainReset;
      integ_gain_q    <= IntegGainReset;
      max_speed_q     <= MaxSpeedReset;
      min_speed_q     <= MinSpeedReset;
      relative_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_THRESHOLDS: thresholds_q    <= cfg_wdata_i;
        REG_PROP_GAIN:  prop_gain_q     <= cfg_wdata_i[PGainW-1:0];
        REG_INTEG_GAIN: integ_gain_q    <= cfg_wdata_i[IGainW-1:0];
        REG_MAX_SPEED:  max_speed_q     <= cfg_wdata_i[SpeedW-1:0];
        REG_MIN_SPEED:  min_speed_q     <= cfg_wdata_i[SpeedW-1:0];
        REG_REL_MODE:   relative_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  lsps_front u_front (
    .samples_i       (samples),
    .thresholds_i    (thresholds_q),
    .relative_mode_i (relative_mode_q),
    .item_o          (front_item)
  );

  lsps_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  lsps_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .prop_gain_i      (prop_gain_q),
    .integ_gain_i     (integ_gain_q),
    .max_speed_i      (max_speed_q),
    .min_speed_i      (min_speed_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .left_duty_o      (left_duty_o),
    .right_duty_o     (right_duty_o),
    .line_pattern_o   (line_pattern_o),
    .line_is_white_o  (line_is_white_o),
    .position_error_o (position_error_o)
  );

endmodule
